@@ src/knlerp_pkg.sv @@
// Shared constants, codes and types of the keyframe sampler.
`timescale 1ns / 1ps

package knlerp_pkg;

  localparam int CHANNELS    = 64;
  localparam int MAX_SAMPLES = 1024;

  localparam int CH_W    = 6;
  localparam int KEY_W   = 10;
  localparam int ADDR_W  = CH_W + KEY_W;
  localparam int CNT_W   = 11;
  localparam int FR_W    = 16;
  localparam int DW      = 32;
  localparam int FRAC_W  = 16;
  localparam int P_W     = 48;
  localparam int LOW_W   = P_W - 24;
  localparam int MAG_W   = 30;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_BITS   = 17;
  localparam int PREP_LAT   = 5;
  localparam int ROT_LAT    = PREP_LAT + SQRT_STEPS + DIV_BITS;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_RATE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 1'b1;

  localparam int MASK_ROT  = 0;
  localparam int MASK_MOVE = 1;
  localparam int MASK_SIZE = 2;

  typedef enum logic [2:0] {
    CMD_ROT_KEY  = 3'd0,
    CMD_MOVE_KEY = 3'd1,
    CMD_SIZE_KEY = 3'd2,
    CMD_SET_MASK = 3'd3,
    CMD_SAMPLE   = 3'd4
  } cmd_t;

  typedef logic signed [DW-1:0] q16_t;

  typedef struct packed {
    logic [2:0]      cmd;
    logic [CH_W-1:0] ch;
    logic [KEY_W-1:0] key;
    q16_t [3:0]      comp;
    logic [2:0]      mask;
    q16_t            time_offset;
    logic [15:0]     slot;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  mask;
    logic [15:0] slot;
    q16_t [2:0]  move;
    q16_t [2:0]  size;
  } side_t;

  typedef struct packed {
    logic [3:0]             neg;
    logic                   zero;
    logic [3:0][MAG_W-1:0]  mag;
  } rot_side_t;

endpackage

@@ src/knlerp_if.sv @@
// Valid/ready channel interfaces for sample requests and results.
`timescale 1ns / 1ps

interface knlerp_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic [5:0]         channel;
  logic [9:0]         key_index;
  logic signed [31:0] comp_x;
  logic signed [31:0] comp_y;
  logic signed [31:0] comp_z;
  logic signed [31:0] comp_w;
  logic [2:0]         mask_in;
  logic signed [31:0] time_offset;
  logic [15:0]        target_slot;

  modport source (output valid, command, channel, key_index, comp_x, comp_y, comp_z, comp_w,
                  mask_in, time_offset, target_slot, input ready);
  modport sink (input valid, command, channel, key_index, comp_x, comp_y, comp_z, comp_w,
                mask_in, time_offset, target_slot, output ready);
endinterface

interface knlerp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rot_x;
  logic signed [31:0] rot_y;
  logic signed [31:0] rot_z;
  logic signed [31:0] rot_w;
  logic signed [31:0] move_x;
  logic signed [31:0] move_y;
  logic signed [31:0] move_z;
  logic signed [31:0] size_x;
  logic signed [31:0] size_y;
  logic signed [31:0] size_z;
  logic [2:0]         mask_out;
  logic [15:0]        slot_out;

  modport source (output valid, rot_x, rot_y, rot_z, rot_w, move_x, move_y, move_z,
                  size_x, size_y, size_z, mask_out, slot_out, input ready);
  modport sink (input valid, rot_x, rot_y, rot_z, rot_w, move_x, move_y, move_z,
                size_x, size_y, size_z, mask_out, slot_out, output ready);
endinterface

@@ src/knlerp_ram.sv @@
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps

module knlerp_ram #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [DATA_W-1:0] rdata_a,
  output logic [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (en) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ src/knlerp_front.sv @@
// Front stages: time scaling, key addressing, key memories and linear interpolation.
`timescale 1ns / 1ps

module knlerp_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  knlerp_pkg::in_word_t               in_word,
  input  logic [knlerp_pkg::FR_W-1:0]        key_rate,
  input  logic [knlerp_pkg::CNT_W-1:0]       sample_count,
  output logic                               out_valid,
  output knlerp_pkg::q16_t [3:0]             rot_q,
  output knlerp_pkg::side_t                  side
);
  import knlerp_pkg::*;

  localparam int LANES = 10;
  localparam int PROD_W = 50;

  // Stage 1: accepted word.
  logic     s1_valid_r;
  in_word_t s1_word_r;

  // Stage 2: scaled position.
  logic           s2_valid_r;
  in_word_t       s2_word_r;
  logic [P_W-1:0] s2_p_r;

  // Stage 3: key words read.
  logic              s3_valid_r;
  logic [FRAC_W-1:0] s3_f_r;
  logic [15:0]       s3_slot_r;
  logic [2:0]        s3_mask_r;
  logic              s3_mvld_r;

  // Stage 4: products.
  logic                     s4_valid_r;
  logic signed [PROD_W-1:0] s4_prod_r [LANES];
  q16_t                     s4_a_r [LANES];
  logic [15:0]              s4_slot_r;
  logic [2:0]               s4_mask_r;

  // Stage 5: interpolated components.
  logic        s5_valid_r;
  q16_t        s5_q_r [LANES];
  logic [15:0] s5_slot_r;
  logic [2:0]  s5_mask_r;

  logic [2:0]       mask_mem [CHANNELS];
  logic [CHANNELS-1:0] mask_vld_r;

  logic signed [P_W:0] p_full;
  assign p_full = $signed(s1_word_r.time_offset) * $signed({1'b0, key_rate});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_word_r <= in_word;
      s2_word_r <= s1_word_r;
      s2_p_r    <= p_full[P_W-1:0];
    end
  end

  // Index clamp and write decode on stage 2.
  logic signed [LOW_W-1:0] low;
  logic [CNT_W-1:0]        cnt, cnt_m1, lo, lo_p1, hi;
  logic                    ch_ok, key_ok, wr, s2_sample;
  logic [ADDR_W-1:0]       waddr, addr_lo, addr_hi;

  assign low = s2_p_r[P_W-1:24];

  always_comb begin
    if (sample_count == '0) begin
      cnt = CNT_W'(1);
    end else if (sample_count > CNT_W'(MAX_SAMPLES)) begin
      cnt = CNT_W'(MAX_SAMPLES);
    end else begin
      cnt = sample_count;
    end
    cnt_m1 = cnt - CNT_W'(1);
    if (low < 0) begin
      lo = '0;
    end else if (low > $signed(LOW_W'(cnt_m1))) begin
      lo = cnt_m1;
    end else begin
      lo = low[CNT_W-1:0];
    end
    lo_p1 = lo + CNT_W'(1);
    hi = (lo_p1 < cnt_m1) ? lo_p1 : cnt_m1;
  end

  assign ch_ok     = {1'b0, s2_word_r.ch} < (CH_W + 1)'(CHANNELS);
  assign key_ok    = {1'b0, s2_word_r.key} < (KEY_W + 1)'(MAX_SAMPLES);
  assign wr        = en && s2_valid_r && ch_ok && key_ok;
  assign s2_sample = s2_word_r.cmd == CMD_SAMPLE;
  assign waddr     = {s2_word_r.ch, s2_word_r.key};
  assign addr_lo   = {s2_word_r.ch, lo[KEY_W-1:0]};
  assign addr_hi   = {s2_word_r.ch, hi[KEY_W-1:0]};

  logic [4*DW-1:0] rot_a, rot_b;
  logic [3*DW-1:0] move_a, move_b, size_a, size_b;

  knlerp_ram #(.ADDR_W(ADDR_W), .DATA_W(4 * DW)) u_rot_ram (
    .clk(clk), .en(en), .we(wr && (s2_word_r.cmd == CMD_ROT_KEY)),
    .waddr(waddr), .wdata(s2_word_r.comp),
    .raddr_a(addr_lo), .raddr_b(addr_hi), .rdata_a(rot_a), .rdata_b(rot_b)
  );

  knlerp_ram #(.ADDR_W(ADDR_W), .DATA_W(3 * DW)) u_move_ram (
    .clk(clk), .en(en), .we(wr && (s2_word_r.cmd == CMD_MOVE_KEY)),
    .waddr(waddr), .wdata(s2_word_r.comp[2:0]),
    .raddr_a(addr_lo), .raddr_b(addr_hi), .rdata_a(move_a), .rdata_b(move_b)
  );

  knlerp_ram #(.ADDR_W(ADDR_W), .DATA_W(3 * DW)) u_size_ram (
    .clk(clk), .en(en), .we(wr && (s2_word_r.cmd == CMD_SIZE_KEY)),
    .waddr(waddr), .wdata(s2_word_r.comp[2:0]),
    .raddr_a(addr_lo), .raddr_b(addr_hi), .rdata_a(size_a), .rdata_b(size_b)
  );

  // Channel masks: a memory plus valid bits, so a never-set mask reads as zero.
  always_ff @(posedge clk) begin
    if (en && s2_valid_r && ch_ok && (s2_word_r.cmd == CMD_SET_MASK)) begin
      mask_mem[s2_word_r.ch] <= s2_word_r.mask;
    end
    if (en) begin
      s3_mask_r <= mask_mem[s2_word_r.ch];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_vld_r <= '0;
    end else if (en && s2_valid_r && ch_ok && (s2_word_r.cmd == CMD_SET_MASK)) begin
      mask_vld_r[s2_word_r.ch] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid_r && s2_sample;
      s4_valid_r <= s3_valid_r;
      s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_f_r    <= s2_p_r[23:8];
      s3_slot_r <= s2_word_r.slot;
      s3_mvld_r <= mask_vld_r[s2_word_r.ch] && ch_ok;
    end
  end

  // Lanes 0..3 rotation, 4..6 translation, 7..9 scale.
  q16_t                     lane_a [LANES];
  q16_t                     lane_b [LANES];
  logic signed [DW:0]       lane_d [LANES];
  logic signed [PROD_W-1:0] lane_prod [LANES];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lane_a[i] = rot_a[i*DW +: DW];
      lane_b[i] = rot_b[i*DW +: DW];
    end
    for (int i = 0; i < 3; i++) begin
      lane_a[4+i] = move_a[i*DW +: DW];
      lane_b[4+i] = move_b[i*DW +: DW];
      lane_a[7+i] = size_a[i*DW +: DW];
      lane_b[7+i] = size_b[i*DW +: DW];
    end
    for (int i = 0; i < LANES; i++) begin
      lane_d[i] = $signed({lane_b[i][DW-1], lane_b[i]}) - $signed({lane_a[i][DW-1], lane_a[i]});
      lane_prod[i] = lane_d[i] * $signed({1'b0, s3_f_r});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        s4_prod_r[i] <= lane_prod[i];
        s4_a_r[i]    <= lane_a[i];
      end
      s4_slot_r <= s3_slot_r;
      s4_mask_r <= s3_mvld_r ? s3_mask_r : 3'b000;
    end
  end

  // a + floor((d * f + half) / 2^16); the result always lies between the two keys.
  logic signed [PROD_W-1:0] lane_rnd [LANES];
  logic signed [DW+1:0]     lane_res [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      lane_rnd[i] = s4_prod_r[i] + PROD_W'(32768);
      lane_res[i] = $signed(lane_rnd[i][PROD_W-1:16])
                    + $signed({{2{s4_a_r[i][DW-1]}}, s4_a_r[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        s5_q_r[i] <= lane_res[i][DW-1:0];
      end
      s5_slot_r <= s4_slot_r;
      s5_mask_r <= s4_mask_r;
    end
  end

  assign out_valid = s5_valid_r;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rot_q[i] = s5_q_r[i];
    end
    for (int i = 0; i < 3; i++) begin
      side.move[i] = s5_q_r[4+i];
      side.size[i] = s5_q_r[7+i];
    end
    side.mask = s5_mask_r;
    side.slot = s5_slot_r;
  end

endmodule

@@ src/knlerp_norm.sv @@
// Rotation prepare stages: magnitudes, common normalizing shift, squares and their sum.
`timescale 1ns / 1ps

module knlerp_norm (
  input  logic                    clk,
  input  logic                    en,
  input  knlerp_pkg::q16_t [3:0]  q,
  output knlerp_pkg::rot_side_t   side,
  output logic [61:0]             sum
);
  import knlerp_pkg::*;

  logic [DW-1:0]    r1_mag_r [4];
  logic [3:0]       r1_neg_r;
  logic [DW-1:0]    r1_mx_r;

  logic [DW-1:0]    r2_mag_r [4];
  logic [3:0]       r2_neg_r;
  logic [4:0]       r2_msb_r;
  logic             r2_zero_r;

  logic [MAG_W-1:0] r3_m_r [4];
  logic [3:0]       r3_neg_r;
  logic             r3_zero_r;

  logic [59:0]      r4_sq_r [4];
  rot_side_t        r4_side_r;
  rot_side_t        r5_side_r;
  logic [61:0]      r5_sum_r;

  logic [DW-1:0] mag [4];
  logic [DW-1:0] m01, m23, mx;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i] = q[i][DW-1] ? DW'(-q[i]) : DW'(q[i]);
    end
    m01 = (mag[0] > mag[1]) ? mag[0] : mag[1];
    m23 = (mag[2] > mag[3]) ? mag[2] : mag[3];
    mx  = (m01 > m23) ? m01 : m23;
  end

  logic [4:0] msb;
  always_comb begin
    msb = '0;
    for (int b = 0; b < DW; b++) begin
      if (r1_mx_r[b]) begin
        msb = 5'(b);
      end
    end
  end

  // Shift all four together so the largest lands in [2^29, 2^30).
  logic [MAG_W-1:0] shifted [4];
  logic [4:0]       shr, shl;
  logic             go_right;

  always_comb begin
    go_right = r2_msb_r >= 5'(MAG_W);
    shr = r2_msb_r - 5'(MAG_W - 1);
    shl = 5'(MAG_W - 1) - r2_msb_r;
    for (int i = 0; i < 4; i++) begin
      if (go_right) begin
        shifted[i] = MAG_W'(r2_mag_r[i] >> shr);
      end else begin
        shifted[i] = MAG_W'(r2_mag_r[i] << shl);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        r1_mag_r[i] <= mag[i];
        r1_neg_r[i] <= q[i][DW-1];
        r2_mag_r[i] <= r1_mag_r[i];
        r3_m_r[i]   <= shifted[i];
        r4_sq_r[i]  <= 60'(r3_m_r[i]) * 60'(r3_m_r[i]);
        r4_side_r.mag[i] <= r3_m_r[i];
      end
      r1_mx_r   <= mx;
      r2_neg_r  <= r1_neg_r;
      r2_msb_r  <= msb;
      r2_zero_r <= r1_mx_r == '0;
      r3_neg_r  <= r2_neg_r;
      r3_zero_r <= r2_zero_r;
      r4_side_r.neg  <= r3_neg_r;
      r4_side_r.zero <= r3_zero_r;
      r5_side_r <= r4_side_r;
      r5_sum_r  <= 62'(r4_sq_r[0]) + 62'(r4_sq_r[1]) + 62'(r4_sq_r[2]) + 62'(r4_sq_r[3]);
    end
  end

  assign side = r5_side_r;
  assign sum  = r5_sum_r;

endmodule

@@ src/knlerp_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module knlerp_sqrt (
  input  logic                   clk,
  input  logic                   en,
  input  logic [61:0]            sum,
  input  knlerp_pkg::rot_side_t  side_in,
  output logic [31:0]            root,
  output knlerp_pkg::rot_side_t  side_out
);
  import knlerp_pkg::*;

  logic [62:0] s_r   [SQRT_STEPS];
  logic [62:0] res_r [SQRT_STEPS];
  rot_side_t   side_r [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam int SH = 62 - 2 * k;
    logic [62:0] s_in, res_in, bit_v, trial;
    rot_side_t   sd_in;

    if (k == 0) begin : g_first
      assign s_in   = 63'(sum);
      assign res_in = '0;
      assign sd_in  = side_in;
    end else begin : g_next
      assign s_in   = s_r[k-1];
      assign res_in = res_r[k-1];
      assign sd_in  = side_r[k-1];
    end

    assign bit_v = 63'(1) << SH;
    assign trial = res_in + bit_v;

    always_ff @(posedge clk) begin
      if (en) begin
        if (s_in >= trial) begin
          s_r[k]   <= s_in - trial;
          res_r[k] <= (res_in >> 1) + bit_v;
        end else begin
          s_r[k]   <= s_in;
          res_r[k] <= res_in >> 1;
        end
        side_r[k] <= sd_in;
      end
    end
  end

  assign root     = res_r[SQRT_STEPS-1][31:0];
  assign side_out = side_r[SQRT_STEPS-1];

endmodule

@@ src/knlerp_div.sv @@
// Pipelined restoring divider: four rounded quotients |v| * 2^16 / n, one bit per stage.
`timescale 1ns / 1ps

module knlerp_div (
  input  logic                   clk,
  input  logic                   en,
  input  logic [31:0]            root,
  input  knlerp_pkg::rot_side_t  side_in,
  output knlerp_pkg::q16_t [3:0] rot
);
  import knlerp_pkg::*;

  localparam int REM_W = MAG_W + 17;

  logic [REM_W-1:0]    rem_r  [DIV_BITS][4];
  logic [DIV_BITS-1:0] quo_r  [DIV_BITS][4];
  logic [31:0]         n_r    [DIV_BITS];
  rot_side_t           side_r [DIV_BITS];

  for (genvar j = 0; j < DIV_BITS; j++) begin : g_step
    localparam int B = DIV_BITS - 1 - j;
    logic [31:0]         n_in;
    rot_side_t           sd_in;
    logic [REM_W-1:0]    rem_in [4];
    logic [DIV_BITS-1:0] quo_in [4];
    logic [REM_W:0]      dv;

    if (j == 0) begin : g_first
      assign n_in  = root;
      assign sd_in = side_in;
      for (genvar l = 0; l < 4; l++) begin : g_lane
        // The half-divisor offset gives round-to-nearest.
        assign rem_in[l] = (REM_W'(side_in.mag[l]) << 16) + REM_W'(root >> 1);
        assign quo_in[l] = '0;
      end
    end else begin : g_next
      assign n_in  = n_r[j-1];
      assign sd_in = side_r[j-1];
      for (genvar l = 0; l < 4; l++) begin : g_lane
        assign rem_in[l] = rem_r[j-1][l];
        assign quo_in[l] = quo_r[j-1][l];
      end
    end

    assign dv = (REM_W + 1)'(n_in) << B;

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 4; l++) begin
          if ({1'b0, rem_in[l]} >= dv) begin
            rem_r[j][l] <= REM_W'({1'b0, rem_in[l]} - dv);
            quo_r[j][l] <= quo_in[l] | (DIV_BITS'(1) << B);
          end else begin
            rem_r[j][l] <= rem_in[l];
            quo_r[j][l] <= quo_in[l];
          end
        end
        n_r[j]    <= n_in;
        side_r[j] <= sd_in;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (side_r[DIV_BITS-1].zero) begin
        rot[l] = '0;
      end else if (side_r[DIV_BITS-1].neg[l]) begin
        rot[l] = -$signed(DW'(quo_r[DIV_BITS-1][l]));
      end else begin
        rot[l] = $signed(DW'(quo_r[DIV_BITS-1][l]));
      end
    end
  end

endmodule

@@ src/keyframe_nlerp_sampler.sv @@
// Top level of the keyframe sampler: config registers, rotation path, side line, output register.
//
//   channel   dir   handshake      moves
//   in_chan   in    valid/ready    one command word (key write, mask set or sample)
//   out_chan  out   valid/ready    one sampled transform word per sample command
//   cfg_*     in    cfg_we only    key rate or sample count write
//
// One word is accepted per cycle while the pipeline is not frozen. A sample word passes 60
// register stages: 5 front stages (scale, key read, interpolate), 5 normalize stages,
// 32 square-root stages, 17 divider stages and the output register.
// Reset clears the channel masks and loads the default config; key memories are not cleared.
// The pipeline freezes only when the output register holds an untaken word and the last stage
// holds another; in_chan.ready follows that freeze.
`timescale 1ns / 1ps

module keyframe_nlerp_sampler (
  input  logic                                  clk,
  input  logic                                  rst_n,
  knlerp_in_if.sink                             in_chan,
  knlerp_out_if.source                          out_chan,
  input  logic                                  cfg_we,
  input  logic [knlerp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [knlerp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import knlerp_pkg::*;

  logic [FR_W-1:0]  key_rate_r;
  logic [CNT_W-1:0] sample_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_rate_r     <= FR_W'(15360);
      sample_count_r <= CNT_W'(1024);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_RATE:     key_rate_r     <= cfg_data[FR_W-1:0];
        CFG_SAMPLE_COUNT: sample_count_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic               en;
  logic               out_valid_r;
  logic [ROT_LAT-1:0] vld_r;
  side_t              line_r [ROT_LAT];

  assign en = !(out_valid_r && !out_chan.ready && vld_r[ROT_LAT-1]);
  assign in_chan.ready = en;

  in_word_t in_word;
  always_comb begin
    in_word.cmd         = in_chan.command;
    in_word.ch          = in_chan.channel;
    in_word.key         = in_chan.key_index;
    in_word.comp        = {in_chan.comp_w, in_chan.comp_z, in_chan.comp_y, in_chan.comp_x};
    in_word.mask        = in_chan.mask_in;
    in_word.time_offset = in_chan.time_offset;
    in_word.slot        = in_chan.target_slot;
  end

  logic       f_valid;
  q16_t [3:0] f_rot;
  side_t      f_side;

  knlerp_front u_front (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(in_chan.valid && en), .in_word(in_word),
    .key_rate(key_rate_r), .sample_count(sample_count_r),
    .out_valid(f_valid), .rot_q(f_rot), .side(f_side)
  );

  rot_side_t   n_side, s_side;
  logic [61:0] n_sum;
  logic [31:0] root;
  q16_t [3:0]  rot;

  knlerp_norm u_norm (.clk(clk), .en(en), .q(f_rot), .side(n_side), .sum(n_sum));

  knlerp_sqrt u_sqrt (
    .clk(clk), .en(en), .sum(n_sum), .side_in(n_side), .root(root), .side_out(s_side)
  );

  knlerp_div u_div (.clk(clk), .en(en), .root(root), .side_in(s_side), .rot(rot));

  // Translation, scale, mask and slot wait here while the rotation is normalized.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[ROT_LAT-2:0], f_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      line_r[0] <= f_side;
      for (int i = 1; i < ROT_LAT; i++) begin
        line_r[i] <= line_r[i-1];
      end
    end
  end

  side_t       last;
  q16_t [3:0]  o_rot_r;
  q16_t [2:0]  o_move_r, o_size_r;
  logic [2:0]  o_mask_r;
  logic [15:0] o_slot_r;

  assign last = line_r[ROT_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_chan.ready) begin
      out_valid_r <= vld_r[ROT_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_chan.ready) begin
      o_rot_r  <= last.mask[MASK_ROT]  ? rot       : '0;
      o_move_r <= last.mask[MASK_MOVE] ? last.move : '0;
      o_size_r <= last.mask[MASK_SIZE] ? last.size : '0;
      o_mask_r <= last.mask;
      o_slot_r <= last.slot;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.rot_x    = o_rot_r[0];
  assign out_chan.rot_y    = o_rot_r[1];
  assign out_chan.rot_z    = o_rot_r[2];
  assign out_chan.rot_w    = o_rot_r[3];
  assign out_chan.move_x   = o_move_r[0];
  assign out_chan.move_y   = o_move_r[1];
  assign out_chan.move_z   = o_move_r[2];
  assign out_chan.size_x   = o_size_r[0];
  assign out_chan.size_y   = o_size_r[1];
  assign out_chan.size_z   = o_size_r[2];
  assign out_chan.mask_out = o_mask_r;
  assign out_chan.slot_out = o_slot_r;

endmodule

@@ src/knlerp_check.sv @@
// Port-level checker for the keyframe sampler and its bind to the top level.
`timescale 1ns / 1ps

module knlerp_check (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         mask_out,
  input logic signed [31:0] rot_x,
  input logic signed [31:0] rot_y,
  input logic signed [31:0] rot_z,
  input logic signed [31:0] rot_w,
  input logic signed [31:0] move_x,
  input logic signed [31:0] move_y,
  input logic signed [31:0] move_z,
  input logic signed [31:0] size_x,
  input logic signed [31:0] size_y,
  input logic signed [31:0] size_z
);
  import knlerp_pkg::*;

  // A result word is never dropped while the sink stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped under stall");

  // Nothing comes out in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word right after reset");

  a_rot_masked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !mask_out[MASK_ROT] |-> rot_x == 0 && rot_y == 0 && rot_z == 0 && rot_w == 0)
    else $error("rotation not zero for masked-off channel");

  a_move_size_masked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (mask_out[MASK_MOVE] || (move_x == 0 && move_y == 0 && move_z == 0))
               && (mask_out[MASK_SIZE] || (size_x == 0 && size_y == 0 && size_z == 0)))
    else $error("translation or scale not zero for masked-off group");

endmodule

bind keyframe_nlerp_sampler knlerp_check u_check (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_chan.valid), .out_ready(out_chan.ready), .mask_out(out_chan.mask_out),
  .rot_x(out_chan.rot_x), .rot_y(out_chan.rot_y), .rot_z(out_chan.rot_z),
  .rot_w(out_chan.rot_w), .move_x(out_chan.move_x), .move_y(out_chan.move_y),
  .move_z(out_chan.move_z), .size_x(out_chan.size_x), .size_y(out_chan.size_y),
  .size_z(out_chan.size_z)
);
